FILE: hdl/lru_key_value_cache_macros.svh
// ---------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Concurrent assertion wrappers. They compile to nothing when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge of clk outside reset.
`define LKV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge of clk, reset included.
`define LKV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LKV_ASSERT(lbl, prop, msg)
`define LKV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hdl/lkv_pkg.sv
// ---------------------------------------------------------------------------
// LRU key-value cache package
// Field widths, operation codes, defaults and the cell control bundle.
// ---------------------------------------------------------------------------
package lkv_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic cmp_en;  // latch the key compare result
    logic upd_en;  // shift toward the back up to the update position
  } cell_ctrl_t;

endpackage

FILE: hdl/lkv_if.sv
// ---------------------------------------------------------------------------
// LRU key-value cache channels
// Valid/ready interfaces for the request and the response items.
// ---------------------------------------------------------------------------
interface lkv_req_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [lkv_pkg::KEY_W-1:0]         key;
  logic signed [lkv_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic signed [lkv_pkg::VALUE_W-1:0] data;

  modport source (output valid, output found, output data, input ready);
  modport sink   (input valid, input found, input data, output ready);
endinterface

FILE: hdl/lru_key_value_cache.sv
// ---------------------------------------------------------------------------
// LRU key-value cache
// Fully associative get/put store kept in recency order in a row of cells;
// cell 0 is the most recent. A hit or a new key moves to the front.
// ---------------------------------------------------------------------------
//  channel   dir  fields                 handshake
//  req       in   func, key, value       valid/ready
//  rsp       out  found, data            valid/ready
//  cfg       in   capacity (cfg_wdata)   cfg_we, no back-pressure
//
// Each item passes a compare state, which checks the key in every cell at once,
// then an update state, which shifts the cells ahead of the hit or insert position
// and loads the front. A new item is taken in the update state, before the last is done.
// Reset clears the valid marks, the entry count and sets capacity to 16.
// A response that is not taken holds the shift cycle until the output register
// frees; a new item may still be taken while an earlier response waits.
// ---------------------------------------------------------------------------
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache #(
  parameter int DEPTH    = lkv_pkg::DEPTH_DEF,
  parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata,
  lkv_req_if.sink                   req,
  lkv_rsp_if.source                 rsp
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CAPW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

  state_t                      state;
  logic [lkv_pkg::CAP_W-1:0]   capacity;
  logic [CW-1:0]               count;
  logic                        out_valid;
  logic                        out_found;
  logic [lkv_pkg::VALUE_W-1:0] out_data;

  logic                        req_func;
  logic [KEY_BITS-1:0]         req_key;
  logic [lkv_pkg::VALUE_W-1:0] req_value;

  logic [31:0]                 key_wide;
  logic [KEY_BITS-1:0]         key_in;

  logic [DEPTH-1:0]            cell_valid;
  logic [DEPTH-1:0]            match;
  logic [KEY_BITS-1:0]         cell_key   [DEPTH];
  logic [lkv_pkg::VALUE_W-1:0] cell_value [DEPTH];

  lkv_pkg::cell_ctrl_t         ctrl;
  logic [PW-1:0]               pos;
  logic [PW-1:0]               hit_pos;
  logic [lkv_pkg::VALUE_W-1:0] hit_val;
  logic                        hit;
  logic [CAPW-1:0]             cap_ext;
  logic [CAPW-1:0]             eff_cap;
  logic                        full;
  logic [CW-1:0]               count_m1;
  logic                        out_ok;
  logic                        upd_go;
  logic                        grow;
  logic                        accept;
  logic [lkv_pkg::VALUE_W-1:0] front_value;

  // Only the low KEY_BITS bits of the key take part.
  assign key_wide = 32'(req.key);
  assign key_in   = key_wide[KEY_BITS-1:0];

  // Keys are unique among valid cells, so the match vector is one-hot or empty.
  always_comb begin
    hit_pos = '0;
    hit_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        hit_pos = hit_pos | PW'(i);
        hit_val = hit_val | cell_value[i];
      end
    end
  end

  assign hit = |match;

  always_comb begin
    cap_ext = CAPW'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CAPW'(1);
    end else if (cap_ext > CAPW'(DEPTH)) begin
      eff_cap = CAPW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full     = CAPW'(count) >= eff_cap;
  assign count_m1 = count - CW'(1);

  // A hit moves its own cell to the front; a new key evicts the last valid
  // cell when full, otherwise it claims the first free cell.
  always_comb begin
    if (hit) begin
      pos = hit_pos;
    end else if (full) begin
      pos = PW'(count_m1);
    end else begin
      pos = PW'(count);
    end
  end

  assign out_ok       = !out_valid || rsp.ready;
  assign upd_go       = (state == S_UPD) && out_ok;
  assign ctrl.cmp_en  = (state == S_CMP);
  assign ctrl.upd_en  = upd_go && (hit || (req_func == lkv_pkg::FUNC_PUT));
  assign grow         = upd_go && (req_func == lkv_pkg::FUNC_PUT) && !hit && !full;
  assign front_value  = (req_func == lkv_pkg::FUNC_PUT) ? req_value : hit_val;

  assign req.ready = (state == S_IDLE) || upd_go;
  assign accept    = req.valid && req.ready;

  assign rsp.valid = out_valid;
  assign rsp.found = out_found;
  assign rsp.data  = out_data;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                        prev_valid;
    logic [KEY_BITS-1:0]         prev_key;
    logic [lkv_pkg::VALUE_W-1:0] prev_value;

    if (i == 0) begin : g_front
      assign prev_valid = 1'b1;
      assign prev_key   = req_key;
      assign prev_value = front_value;
    end else begin : g_link
      assign prev_valid = cell_valid[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_value = cell_value[i-1];
    end

    lkv_cell #(
      .KEY_BITS (KEY_BITS),
      .PW       (PW),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .pos        (pos),
      .cmp_key    (req_key),
      .prev_valid (prev_valid),
      .prev_key   (prev_key),
      .prev_value (prev_value),
      .valid      (cell_valid[i]),
      .key        (cell_key[i]),
      .value      (cell_value[i]),
      .match      (match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= lkv_pkg::CAP_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      // A new response may replace the one leaving in the same cycle.
      if (upd_go) begin
        out_valid <= 1'b1;
        out_found <= hit;
        out_data  <= (hit && (req_func == lkv_pkg::FUNC_GET)) ? hit_val : '0;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (grow) begin
        count <= count + CW'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (out_ok) begin
            state <= accept ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func  <= req.func;
      req_key   <= key_in;
      req_value <= req.value;
    end
  end

  `LKV_ASSERT(a_unique_hit, (state == S_UPD) |-> $onehot0(match), "several cells matched")
  `LKV_ASSERT(a_valid_count, $countones(cell_valid) == 32'(count), "valid marks vs count")
  `LKV_ASSERT(a_resp_from_upd, $rose(out_valid) |-> $past(state == S_UPD), "response too early")
  `LKV_ASSERT(a_front_valid, ctrl.upd_en |=> cell_valid[0], "front cell not valid")

endmodule

FILE: hdl/lkv_cell.sv
// ---------------------------------------------------------------------------
// LRU key-value cache cell
// One recency slot: holds a key, a value and a valid mark, compares its key
// against the request and takes its front neighbor's contents on a shift.
// ---------------------------------------------------------------------------
module lkv_cell #(
  parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF,
  parameter int PW       = 4,
  parameter int IDX      = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lkv_pkg::cell_ctrl_t         ctrl,
  input  logic [PW-1:0]               pos,
  input  logic [KEY_BITS-1:0]         cmp_key,
  input  logic                        prev_valid,
  input  logic [KEY_BITS-1:0]         prev_key,
  input  logic [lkv_pkg::VALUE_W-1:0] prev_value,
  output logic                        valid,
  output logic [KEY_BITS-1:0]         key,
  output logic [lkv_pkg::VALUE_W-1:0] value,
  output logic                        match
);

  logic shift;

  // Every cell from the front up to the update position moves back by one.
  assign shift = ctrl.upd_en && (PW'(IDX) <= pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.cmp_en) begin
        match <= valid && (key == cmp_key);
      end
      if (shift) begin
        valid <= prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key   <= prev_key;
      value <= prev_value;
    end
  end

endmodule

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and put items through the request channel and checks every
// response against a recency-ordered model of the store. The run walks
// through several capacity settings, including zero and values above the
// cell count. The sender and receiver idle at random, the receiver holds
// off once for a long stretch, and the sender drains before each capacity
// change.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int HOLD_PHASE      = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int POOL_MAX        = 24;

  typedef logic [lkv_pkg::KEY_W-1:0]   key_t;
  typedef logic [lkv_pkg::VALUE_W-1:0] value_t;
  typedef logic [lkv_pkg::CAP_W-1:0]   cap_t;

  class lru_scoreboard;
    typedef struct {
      logic   found;
      value_t data;
    } lookup_t;

    key_t     keys[lkv_pkg::DEPTH_DEF];
    value_t   vals[lkv_pkg::DEPTH_DEF];
    int       count;
    cap_t     capacity;
    lookup_t  pending_lookups[$];
    int       errors;

    function new();
      count    = 0;
      capacity = lkv_pkg::CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(input cap_t c);
      capacity = c;
    endfunction

    // A capacity of zero acts as one; anything above the cell count saturates.
    function int eff_capacity();
      if (capacity == 0) return 1;
      if (capacity > lkv_pkg::DEPTH_DEF) return lkv_pkg::DEPTH_DEF;
      return capacity;
    endfunction

    function int pending();
      return pending_lookups.size();
    endfunction

    function void note_request(input logic func, input key_t key, input value_t value);
      int      hit_at;
      int      last;
      logic    move;
      value_t  front_val;
      lookup_t res;
      hit_at    = -1;
      last      = 0;
      move      = 1'b1;
      front_val = value;
      for (int i = 0; i < count; i++) begin
        if (hit_at < 0 && keys[i] == key) hit_at = i;
      end
      res.found = (hit_at >= 0);
      res.data  = '0;
      if (func == lkv_pkg::FUNC_GET) begin
        if (hit_at >= 0) begin
          res.data  = vals[hit_at];
          front_val = vals[hit_at];
          last      = hit_at;
        end else begin
          move = 1'b0;
        end
      end else if (hit_at >= 0) begin
        last = hit_at;
      end else if (count >= eff_capacity()) begin
        // Only the least recent entry goes, even when the count is above
        // a capacity that was lowered later.
        last = count - 1;
      end else begin
        last = count;
        count++;
      end
      if (move) begin
        for (int i = last; i > 0; i--) begin
          keys[i] = keys[i-1];
          vals[i] = vals[i-1];
        end
        keys[0] = key;
        vals[0] = front_val;
      end
      pending_lookups = {pending_lookups, res};
    endfunction

    function void check_response(input logic found, input value_t data);
      lookup_t exp_res;
      if (pending_lookups.size() == 0) begin
        $error("response with no item outstanding: found=%0b data=%0d",
               found, $signed(data));
        errors++;
        return;
      end
      exp_res = pending_lookups[0];
      pending_lookups.delete(0);
      if (found !== exp_res.found) begin
        $error("found: expected %0b, actual %0b", exp_res.found, found);
        errors++;
      end
      if (data !== exp_res.data) begin
        $error("data: expected %0d, actual %0d", $signed(exp_res.data), $signed(data));
        errors++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          cfg_we;
  cap_t          cfg_wdata;
  int            snd_idle_pct;
  int            rcv_idle_pct;
  int            hold_ask;
  int            idle_cycles;
  lru_scoreboard sb;

  lkv_req_if req();
  lkv_rsp_if rsp();

  lru_key_value_cache uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_req(input logic func, input key_t key, input value_t value);
    while ($urandom_range(99) < snd_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func  <= func;
    req.key   <= key;
    req.value <= value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Stop offering items and wait until every response has come back.
  task automatic drain_responses();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input cap_t c);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(c);
  endtask

  // Item and response monitor.
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) sb.note_request(req.func, req.key, req.value);
      if (rsp.valid && rsp.ready) sb.check_response(rsp.found, rsp.data);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Response sink: random stalls, plus one long hold-off counted here.
  initial begin : rsp_sink
    int hold_left;
    int hold_taken;
    hold_left  = 0;
    hold_taken = 0;
    rsp.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = hold_ask;
      end
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    cap_t   phase_caps[NUM_PHASES];
    key_t   key_pool[POOL_MAX];
    int     pool_n;
    logic   func;
    key_t   key;
    value_t value;

    phase_caps  = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd9, 5'd3, 5'd16,
                    5'd2, 5'd12, 5'd7, 5'd24};
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req.valid    = 1'b0;
    req.func     = lkv_pkg::FUNC_GET;
    req.key      = '0;
    req.value    = '0;
    snd_idle_pct = 37;
    rcv_idle_pct = 84;
    hold_ask     = 0;
    sb           = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset capacity first.
    send_req(lkv_pkg::FUNC_GET, 16'h0000, 32'h0000_0000);   // empty store misses
    send_req(lkv_pkg::FUNC_PUT, 16'h0000, 32'h8000_0000);
    send_req(lkv_pkg::FUNC_PUT, 16'hFFFF, 32'h7FFF_FFFF);
    send_req(lkv_pkg::FUNC_GET, 16'h0000, 32'h1234_5678);   // value is ignored on a get
    send_req(lkv_pkg::FUNC_GET, 16'hFFFF, 32'h0000_0000);
    send_req(lkv_pkg::FUNC_PUT, 16'h0000, 32'hFFFF_FFFF);   // overwrite of a present key
    send_req(lkv_pkg::FUNC_GET, 16'h0000, 32'h0000_0000);
    send_req(lkv_pkg::FUNC_GET, 16'hA5A5, 32'h0000_0000);
    drain_responses();
    write_capacity(5'd2);
    send_req(lkv_pkg::FUNC_PUT, 16'h5A5A, 32'h0000_0005);   // full, least recent is dropped
    send_req(lkv_pkg::FUNC_GET, 16'hFFFF, 32'h0000_0000);
    send_req(lkv_pkg::FUNC_GET, 16'h0000, 32'h0000_0000);
    drain_responses();
    // Capacity now below the count; the count must stay at two.
    write_capacity(5'd1);
    send_req(lkv_pkg::FUNC_PUT, 16'h0001, 32'h0000_0001);
    send_req(lkv_pkg::FUNC_GET, 16'h5A5A, 32'h0000_0000);
    send_req(lkv_pkg::FUNC_GET, 16'h0000, 32'h0000_0000);
    drain_responses();
    write_capacity(5'd0);
    send_req(lkv_pkg::FUNC_PUT, 16'h0002, 32'h0000_0002);
    send_req(lkv_pkg::FUNC_GET, 16'h0001, 32'h0000_0000);
    drain_responses();
    write_capacity(5'd31);
    for (int i = 0; i < 4; i++) begin
      send_req(lkv_pkg::FUNC_PUT, key_t'(16'h0010 + i), value_t'(32'h0000_0100 + i));
    end
    send_req(lkv_pkg::FUNC_GET, 16'h0002, 32'h0000_0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_responses();
      write_capacity(phase_caps[p]);
      if (p < 4) begin
        snd_idle_pct = 37;
        rcv_idle_pct = 84;
      end else if (p < 8) begin
        snd_idle_pct = 84;
        rcv_idle_pct = 37;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if (p == HOLD_PHASE) hold_ask = hold_ask + 1;
      // A key pool up to five keys larger than the capacity gives both hits and evictions.
      pool_n = sb.eff_capacity() + $urandom_range(5);
      for (int i = 0; i < POOL_MAX; i++) key_pool[i] = key_t'($urandom_range(16'hFFFF));
      repeat (ITEMS_PER_PHASE) begin
        func = 1'($urandom_range(1));
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(pool_n - 1)];
        else key = key_t'($urandom_range(16'hFFFF));
        case ($urandom_range(19))
          0:       value = 32'h8000_0000;
          1:       value = 32'h7FFF_FFFF;
          2:       value = 32'h0000_0000;
          3:       value = 32'hFFFF_FFFF;
          default: value = $urandom;
        endcase
        send_req(func, key, value);
      end
    end
    drain_responses();

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/lkv_pkg.sv
hdl/lkv_if.sv
hdl/lkv_cell.sv
hdl/lru_key_value_cache.sv
test/tb_top.sv
